FILE: src/pcmt_pkg.sv
package pcmt_pkg;

    // Operation codes carried on the mode input.
    localparam logic [2:0] MODE_STEP   = 3'd0;
    localparam logic [2:0] MODE_ADDCOP = 3'd1;
    localparam logic [2:0] MODE_ADDRAM = 3'd2;
    localparam logic [2:0] MODE_REMOVE = 3'd3;
    localparam logic [2:0] MODE_CLEAR  = 3'd4;
    localparam logic [2:0] MODE_LIST   = 3'd5;

    // Action codes.
    localparam logic [1:0] ACT_NONE = 2'd0;
    localparam logic [1:0] ACT_COP  = 2'd1;
    localparam logic [1:0] ACT_RAM  = 2'd2;
    localparam logic [1:0] ACT_ACK  = 2'd3;

    // Status codes.
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_REG  = 3'd1;
    localparam logic [2:0] ST_BAD_ADDR = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;
    localparam logic [2:0] ST_EMPTY    = 3'd5;

    localparam logic [31:0] COP_REGS   = 32'd32;
    localparam logic [32:0] WORD_BYTES = 33'd4;
    localparam logic [31:0] HITS_MAX   = 32'hFFFF_FFFF;
    localparam int MAX_RESULTS = 16;
    localparam logic [24:0] RAM_BYTES_RESET = 25'd2097152;

    // One stored rule.
    typedef struct packed {
        logic [31:0] id;
        logic [31:0] pc;
        logic [31:0] target;
        logic [31:0] value;
        logic        ram_kind;
        logic        once;
        logic        enabled;
    } rule_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_SHIFT,
        S_DONE
    } state_t;

    // Ram word fit check shared by add and step.
    function automatic logic ram_fits(input logic [31:0] t, input logic [24:0] size);
        ram_fits = ({1'b0, t} + WORD_BYTES) <= {8'd0, size};
    endfunction

endpackage

FILE: src/pcmt_store.sv
module pcmt_store #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  pcmt_pkg::rule_t      wr_rule,
    input  logic [31:0]          wr_hits,
    input  logic [AW-1:0]        rd_addr,
    output pcmt_pkg::rule_t      rd_rule,
    output logic [31:0]          rd_hits
);

    pcmt_pkg::rule_t rule_mem [DEPTH];
    logic [31:0]     hits_mem [DEPTH];

    // Single write port, single registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            rule_mem[wr_addr] <= wr_rule;
            hits_mem[wr_addr] <= wr_hits;
        end
        rd_rule <= rule_mem[rd_addr];
        rd_hits <= hits_mem[rd_addr];
    end

endmodule

FILE: src/pc_match_action_trigger_table_unit.sv
// Rule table sequencer over one table memory with a registered read port.
// Add, clear and unused modes finish in S_READ and return to idle through S_DONE;
// step, remove and list walk the table entry by entry in S_READ, S_EVAL, S_SHIFT.
// busy is high until the scan ends; the final word strobes by the first idle cycle.
// Results appear for one cycle on done; the receiver cannot stall them.
// Reset (rst_n low, asynchronous) empties the table and sets the next id to 1.
module pc_match_action_trigger_table_unit #(
    parameter int MAX_RULES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  mode,
    input  logic [31:0] pc,
    input  logic [31:0] target,
    input  logic [31:0] value,
    input  logic        once,
    input  logic [31:0] hook_id,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [24:0] cfg_data,
    output logic        done,
    output logic [1:0]  action,
    output logic [2:0]  status,
    output logic [31:0] write_target,
    output logic [31:0] write_value,
    output logic [31:0] rule_id,
    output logic [31:0] count,
    output logic [31:0] entry_pc,
    output logic        entry_kind,
    output logic        entry_once,
    output logic        entry_enabled,
    output logic        last
);

    localparam int AW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int CW = $clog2(MAX_RULES + 1);
    localparam int NW = $clog2(pcmt_pkg::MAX_RESULTS + 1);

    pcmt_pkg::state_t state_reg, state_next;
    logic [CW-1:0] rule_count_reg, rule_count_next;
    logic [31:0]   next_id_reg, next_id_next;
    logic [24:0]   ram_bytes_reg;
    logic [CW-1:0] idx_reg, idx_next;
    logic [NW-1:0] nout_reg, nout_next;
    logic          found_reg, found_next;
    logic [2:0]    mode_reg;
    logic [31:0]   pc_q_reg, target_q_reg, value_q_reg, hid_q_reg;
    logic          once_q_reg;

    // Result register.
    logic          done_reg, done_next;
    logic [1:0]    act_reg, act_next;
    logic [2:0]    st_reg, st_next;
    logic [31:0]   wt_reg, wt_next, wv_reg, wv_next, id_reg, id_next, cnt_reg, cnt_next;
    logic [31:0]   epc_reg, epc_next;
    logic          ekind_reg, ekind_next, eonce_reg, eonce_next, een_reg, een_next;
    logic          last_reg, last_next;

    // Step word held back until it is known whether another one follows.
    logic            hold_reg, hold_next;
    logic [1:0]      hold_act_reg, hold_act_next;
    logic [2:0]      hold_st_reg, hold_st_next;
    pcmt_pkg::rule_t hold_rule_reg, hold_rule_next;
    logic [31:0]     hold_hits_reg, hold_hits_next;

    logic            wr_en;
    logic [AW-1:0]   wr_addr, rd_addr;
    pcmt_pkg::rule_t wr_rule, rd_rule, new_rule;
    logic [31:0]     wr_hits, rd_hits, hits_inc;
    logic            at_end, match;

    pcmt_store #(.DEPTH(MAX_RULES), .AW(AW)) u_store (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_rule(wr_rule),
        .wr_hits(wr_hits),
        .rd_addr(rd_addr),
        .rd_rule(rd_rule),
        .rd_hits(rd_hits)
    );

    assign busy      = (state_reg != pcmt_pkg::S_IDLE);
    assign cfg_ready = !busy && !start;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ram_bytes_reg <= pcmt_pkg::RAM_BYTES_RESET;
        else if (cfg_valid && cfg_ready)
            ram_bytes_reg <= cfg_data;
    end

    // Captured command word.
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            mode_reg     <= mode;
            pc_q_reg     <= pc;
            target_q_reg <= target;
            value_q_reg  <= value;
            once_q_reg   <= once;
            hid_q_reg    <= hook_id;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pcmt_pkg::S_IDLE;
            rule_count_reg <= '0;
            next_id_reg    <= 32'd1;
            done_reg       <= 1'b0;
            idx_reg        <= '0;
            nout_reg       <= '0;
            found_reg      <= 1'b0;
            hold_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rule_count_reg <= rule_count_next;
            next_id_reg    <= next_id_next;
            done_reg       <= done_next;
            idx_reg        <= idx_next;
            nout_reg       <= nout_next;
            found_reg      <= found_next;
            hold_reg       <= hold_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg       <= act_next;
        st_reg        <= st_next;
        wt_reg        <= wt_next;
        wv_reg        <= wv_next;
        id_reg        <= id_next;
        cnt_reg       <= cnt_next;
        epc_reg       <= epc_next;
        ekind_reg     <= ekind_next;
        eonce_reg     <= eonce_next;
        een_reg       <= een_next;
        last_reg      <= last_next;
        hold_act_reg  <= hold_act_next;
        hold_st_reg   <= hold_st_next;
        hold_rule_reg <= hold_rule_next;
        hold_hits_reg <= hold_hits_next;
    end

    assign at_end   = (idx_reg >= rule_count_reg);
    assign match    = rd_rule.enabled && (rd_rule.pc == pc_q_reg);
    assign hits_inc = (rd_hits == pcmt_pkg::HITS_MAX) ? rd_hits : rd_hits + 32'd1;

    always_comb
    begin
        new_rule          = '0;
        new_rule.id       = next_id_reg;
        new_rule.pc       = pc_q_reg;
        new_rule.target   = target_q_reg;
        new_rule.value    = value_q_reg;
        new_rule.ram_kind = (mode_reg == pcmt_pkg::MODE_ADDRAM);
        new_rule.once     = once_q_reg;
        new_rule.enabled  = 1'b1;
    end

    // Sequencer: next state, table access and result word.
    always_comb
    begin
        state_next      = state_reg;
        rule_count_next = rule_count_reg;
        next_id_next    = next_id_reg;
        idx_next        = idx_reg;
        nout_next       = nout_reg;
        found_next      = found_reg;
        hold_next       = hold_reg;
        hold_act_next   = hold_act_reg;
        hold_st_next    = hold_st_reg;
        hold_rule_next  = hold_rule_reg;
        hold_hits_next  = hold_hits_reg;
        done_next       = 1'b0;
        act_next        = pcmt_pkg::ACT_NONE;
        st_next         = pcmt_pkg::ST_OK;
        wt_next         = '0;
        wv_next         = '0;
        id_next         = '0;
        cnt_next        = '0;
        epc_next        = '0;
        ekind_next      = 1'b0;
        eonce_next      = 1'b0;
        een_next        = 1'b0;
        last_next       = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = idx_reg[AW-1:0];
        wr_rule         = rd_rule;
        wr_hits         = rd_hits;
        rd_addr         = idx_reg[AW-1:0];
        case (state_reg)
            pcmt_pkg::S_IDLE:
            begin
                if (start)
                begin
                    idx_next   = '0;
                    nout_next  = '0;
                    found_next = 1'b0;
                    hold_next  = 1'b0;
                    state_next = pcmt_pkg::S_READ;
                end
            end
            pcmt_pkg::S_READ:
            begin
                // Scanning modes read entry idx; the others finish here.
                case (mode_reg)
                    pcmt_pkg::MODE_STEP, pcmt_pkg::MODE_REMOVE, pcmt_pkg::MODE_LIST:
                    begin
                        if (at_end)
                            state_next = pcmt_pkg::S_DONE;
                        else if (found_reg)
                        begin
                            rd_addr    = AW'(idx_reg + CW'(1));
                            state_next = (idx_reg + CW'(1) >= rule_count_reg) ?
                                         pcmt_pkg::S_DONE : pcmt_pkg::S_SHIFT;
                            if (state_next == pcmt_pkg::S_DONE)
                                rule_count_next = rule_count_reg - CW'(1);
                        end
                        else
                            state_next = pcmt_pkg::S_EVAL;
                    end
                    pcmt_pkg::MODE_ADDCOP, pcmt_pkg::MODE_ADDRAM:
                    begin
                        act_next   = pcmt_pkg::ACT_ACK;
                        wt_next    = target_q_reg;
                        wv_next    = value_q_reg;
                        epc_next   = pc_q_reg;
                        ekind_next = new_rule.ram_kind;
                        eonce_next = once_q_reg;
                        een_next   = 1'b1;
                        if (mode_reg == pcmt_pkg::MODE_ADDCOP &&
                            target_q_reg >= pcmt_pkg::COP_REGS)
                            st_next = pcmt_pkg::ST_BAD_REG;
                        else if (mode_reg == pcmt_pkg::MODE_ADDRAM &&
                                 !pcmt_pkg::ram_fits(target_q_reg, ram_bytes_reg))
                            st_next = pcmt_pkg::ST_BAD_ADDR;
                        else if (rule_count_reg >= CW'(MAX_RULES))
                            st_next = pcmt_pkg::ST_FULL;
                        else
                        begin
                            id_next         = next_id_reg;
                            next_id_next    = next_id_reg + 32'd1;
                            wr_en           = 1'b1;
                            wr_addr         = rule_count_reg[AW-1:0];
                            wr_rule         = new_rule;
                            wr_hits         = '0;
                            rule_count_next = rule_count_reg + CW'(1);
                        end
                        done_next  = 1'b1;
                        last_next  = 1'b1;
                        state_next = pcmt_pkg::S_DONE;
                    end
                    pcmt_pkg::MODE_CLEAR:
                    begin
                        act_next        = pcmt_pkg::ACT_ACK;
                        cnt_next        = 32'(rule_count_reg);
                        rule_count_next = '0;
                        done_next       = 1'b1;
                        last_next       = 1'b1;
                        state_next      = pcmt_pkg::S_DONE;
                    end
                    default:
                    begin
                        done_next  = 1'b1;
                        last_next  = 1'b1;
                        state_next = pcmt_pkg::S_DONE;
                    end
                endcase
            end
            pcmt_pkg::S_EVAL:
            begin
                idx_next   = idx_reg + CW'(1);
                state_next = pcmt_pkg::S_READ;
                wr_rule    = rd_rule;
                if (mode_reg == pcmt_pkg::MODE_STEP)
                begin
                    // A firing entry's word waits in the hold register until the next
                    // firing entry or the end of the scan shows whether it is the last.
                    if (match)
                    begin
                        wr_en           = 1'b1;
                        wr_hits         = hits_inc;
                        wr_rule.enabled = !rd_rule.once;
                        if (nout_reg < NW'(pcmt_pkg::MAX_RESULTS))
                        begin
                            nout_next      = nout_reg + NW'(1);
                            hold_next      = 1'b1;
                            hold_rule_next = wr_rule;
                            hold_hits_next = hits_inc;
                            hold_act_next  = pcmt_pkg::ACT_COP;
                            hold_st_next   = pcmt_pkg::ST_OK;
                            if (rd_rule.ram_kind)
                            begin
                                if (pcmt_pkg::ram_fits(rd_rule.target, ram_bytes_reg))
                                    hold_act_next = pcmt_pkg::ACT_RAM;
                                else
                                begin
                                    hold_act_next = pcmt_pkg::ACT_NONE;
                                    hold_st_next  = pcmt_pkg::ST_BAD_ADDR;
                                end
                            end
                            if (hold_reg)
                            begin
                                done_next  = 1'b1;
                                act_next   = hold_act_reg;
                                st_next    = hold_st_reg;
                                cnt_next   = hold_hits_reg;
                                wt_next    = hold_rule_reg.target;
                                wv_next    = hold_rule_reg.value;
                                id_next    = hold_rule_reg.id;
                                epc_next   = hold_rule_reg.pc;
                                ekind_next = hold_rule_reg.ram_kind;
                                eonce_next = hold_rule_reg.once;
                                een_next   = hold_rule_reg.enabled;
                            end
                        end
                    end
                end
                else if (mode_reg == pcmt_pkg::MODE_LIST)
                begin
                    done_next  = (nout_reg < NW'(pcmt_pkg::MAX_RESULTS));
                    nout_next  = done_next ? nout_reg + NW'(1) : nout_reg;
                    act_next   = pcmt_pkg::ACT_ACK;
                    cnt_next   = rd_hits;
                    wt_next    = rd_rule.target;
                    wv_next    = rd_rule.value;
                    id_next    = rd_rule.id;
                    epc_next   = rd_rule.pc;
                    ekind_next = rd_rule.ram_kind;
                    eonce_next = rd_rule.once;
                    een_next   = rd_rule.enabled;
                    // The final word of a listing: no later entry can emit.
                    last_next  = (idx_reg + CW'(1) >= rule_count_reg) ||
                                 (nout_next == NW'(pcmt_pkg::MAX_RESULTS) && done_next);
                end
                else
                begin
                    // Remove: on the first id match, later entries move down.
                    if (rd_rule.id == hid_q_reg)
                    begin
                        found_next = 1'b1;
                        idx_next   = idx_reg;
                    end
                end
            end
            pcmt_pkg::S_SHIFT:
            begin
                // rd_rule holds entry idx+1; move it to idx.
                wr_en      = 1'b1;
                wr_addr    = idx_reg[AW-1:0];
                idx_next   = idx_reg + CW'(1);
                state_next = pcmt_pkg::S_READ;
            end
            pcmt_pkg::S_DONE:
            begin
                // Closing word where the scan has not already marked one last.
                state_next = pcmt_pkg::S_IDLE;
                if (mode_reg == pcmt_pkg::MODE_REMOVE)
                begin
                    done_next = 1'b1;
                    last_next = 1'b1;
                    act_next  = pcmt_pkg::ACT_ACK;
                    id_next   = hid_q_reg;
                    st_next   = found_reg ? pcmt_pkg::ST_OK : pcmt_pkg::ST_NOTFOUND;
                end
                else if (mode_reg == pcmt_pkg::MODE_STEP && hold_reg)
                begin
                    done_next  = 1'b1;
                    last_next  = 1'b1;
                    act_next   = hold_act_reg;
                    st_next    = hold_st_reg;
                    cnt_next   = hold_hits_reg;
                    wt_next    = hold_rule_reg.target;
                    wv_next    = hold_rule_reg.value;
                    id_next    = hold_rule_reg.id;
                    epc_next   = hold_rule_reg.pc;
                    ekind_next = hold_rule_reg.ram_kind;
                    eonce_next = hold_rule_reg.once;
                    een_next   = hold_rule_reg.enabled;
                end
                else if ((mode_reg == pcmt_pkg::MODE_STEP || mode_reg == pcmt_pkg::MODE_LIST)
                         && nout_reg == '0)
                begin
                    done_next = 1'b1;
                    last_next = 1'b1;
                    st_next   = (mode_reg == pcmt_pkg::MODE_LIST) ?
                                pcmt_pkg::ST_EMPTY : pcmt_pkg::ST_OK;
                end
            end
            default:
                state_next = pcmt_pkg::S_IDLE;
        endcase
    end

    assign done          = done_reg;
    assign action        = act_reg;
    assign status        = st_reg;
    assign write_target  = wt_reg;
    assign write_value   = wv_reg;
    assign rule_id       = id_reg;
    assign count         = cnt_reg;
    assign entry_pc      = epc_reg;
    assign entry_kind    = ekind_reg;
    assign entry_once    = eonce_reg;
    assign entry_enabled = een_reg;
    // A step's last flag only stands on a word that really goes out.
    assign last          = last_reg;

    // The table never holds more rules than it has room for.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rule_count_reg <= CW'(MAX_RULES))
        else $error("rule count exceeds table size");

    // An accepted command always makes the block busy next cycle.
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("command accepted but block not busy");

    // A clear empties the table.
    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pcmt_pkg::S_READ && mode_reg == pcmt_pkg::MODE_CLEAR)
        |=> rule_count_reg == '0)
        else $error("clear left rules in table");

endmodule

FILE: test/tb_pc_match_action_trigger_table_unit.sv
`timescale 1ns / 100ps

module tb_pc_match_action_trigger_table_unit;

    localparam int TABLE_DEPTH = 16;

    // One result word as the block presents it.
    typedef struct {
        logic [1:0]  action;
        logic [2:0]  status;
        logic [31:0] write_target;
        logic [31:0] write_value;
        logic [31:0] rule_id;
        logic [31:0] count;
        logic [31:0] entry_pc;
        logic        entry_kind;
        logic        entry_once;
        logic        entry_enabled;
        logic        last;
    } trig_word_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  mode;
    logic [31:0] pc;
    logic [31:0] target;
    logic [31:0] value;
    logic        once;
    logic [31:0] hook_id;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [24:0] cfg_data;
    logic        done;
    logic [1:0]  action;
    logic [2:0]  status;
    logic [31:0] write_target;
    logic [31:0] write_value;
    logic [31:0] rule_id;
    logic [31:0] count;
    logic [31:0] entry_pc;
    logic        entry_kind;
    logic        entry_once;
    logic        entry_enabled;
    logic        last;

    // Shadow copy of the trigger table.
    pcmt_pkg::rule_t shadow_rules [TABLE_DEPTH];
    logic [31:0]     shadow_hits [TABLE_DEPTH];
    int              shadow_count;
    logic [31:0]     shadow_next_id;
    logic [24:0]     shadow_ram_bytes;

    trig_word_t  pending_words [$];
    int          fail_count;

    pc_match_action_trigger_table_unit #(.MAX_RULES(TABLE_DEPTH)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .mode(mode), .pc(pc),
        .target(target), .value(value), .once(once), .hook_id(hook_id),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .done(done), .action(action), .status(status), .write_target(write_target),
        .write_value(write_value), .rule_id(rule_id), .count(count),
        .entry_pc(entry_pc), .entry_kind(entry_kind), .entry_once(entry_once),
        .entry_enabled(entry_enabled), .last(last)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic word_fits(input logic [31:0] addr);
        return ({1'b0, addr} + pcmt_pkg::WORD_BYTES) <= {8'd0, shadow_ram_bytes};
    endfunction

    function automatic trig_word_t make_word(input logic [1:0] act, input logic [2:0] st,
                                             input logic has_rule, input pcmt_pkg::rule_t r,
                                             input logic [31:0] id, input logic [31:0] cnt);
        trig_word_t w;
        w = '{default: '0};
        w.action  = act;
        w.status  = st;
        w.rule_id = id;
        w.count   = cnt;
        if (has_rule)
        begin
            w.write_target  = r.target;
            w.write_value   = r.value;
            w.entry_pc      = r.pc;
            w.entry_kind    = r.ram_kind;
            w.entry_once    = r.once;
            w.entry_enabled = r.enabled;
        end
        return w;
    endfunction

    // Works out the result words of one accepted command and updates the shadow table.
    task automatic predict_command(input logic [2:0] m, input logic [31:0] p,
                                   input logic [31:0] t, input logic [31:0] v,
                                   input logic o, input logic [31:0] hid);
        trig_word_t      words [$];
        pcmt_pkg::rule_t nr;
        logic [1:0]      act;
        logic [2:0]      st;
        logic [31:0]     id;
        int              found;
        nr = '0;
        case (m)
            pcmt_pkg::MODE_STEP:
            begin
                for (int i = 0; i < shadow_count; i++)
                begin
                    if (shadow_rules[i].enabled && shadow_rules[i].pc == p)
                    begin
                        if (shadow_hits[i] != pcmt_pkg::HITS_MAX)
                            shadow_hits[i]++;
                        act = pcmt_pkg::ACT_COP;
                        st = pcmt_pkg::ST_OK;
                        if (shadow_rules[i].ram_kind)
                        begin
                            if (word_fits(shadow_rules[i].target))
                                act = pcmt_pkg::ACT_RAM;
                            else
                            begin
                                act = pcmt_pkg::ACT_NONE;
                                st = pcmt_pkg::ST_BAD_ADDR;
                            end
                        end
                        if (shadow_rules[i].once)
                            shadow_rules[i].enabled = 1'b0;
                        if (words.size() < pcmt_pkg::MAX_RESULTS)
                            words = {words, make_word(act, st, 1'b1, shadow_rules[i],
                                                      shadow_rules[i].id, shadow_hits[i])};
                    end
                end
                if (words.size() == 0)
                    words = {words, make_word(pcmt_pkg::ACT_NONE, pcmt_pkg::ST_OK, 1'b0,
                                              nr, '0, '0)};
            end
            pcmt_pkg::MODE_ADDCOP, pcmt_pkg::MODE_ADDRAM:
            begin
                nr.pc = p;
                nr.target = t;
                nr.value = v;
                nr.ram_kind = (m == pcmt_pkg::MODE_ADDRAM);
                nr.once = o;
                nr.enabled = 1'b1;
                st = pcmt_pkg::ST_OK;
                id = '0;
                if (m == pcmt_pkg::MODE_ADDCOP && t >= pcmt_pkg::COP_REGS)
                    st = pcmt_pkg::ST_BAD_REG;
                else if (m == pcmt_pkg::MODE_ADDRAM && !word_fits(t))
                    st = pcmt_pkg::ST_BAD_ADDR;
                else if (shadow_count >= TABLE_DEPTH)
                    st = pcmt_pkg::ST_FULL;
                if (st == pcmt_pkg::ST_OK)
                begin
                    id = shadow_next_id;
                    shadow_next_id++;
                    nr.id = id;
                    shadow_rules[shadow_count] = nr;
                    shadow_hits[shadow_count] = '0;
                    shadow_count++;
                end
                words = {words, make_word(pcmt_pkg::ACT_ACK, st, 1'b1, nr, id, '0)};
            end
            pcmt_pkg::MODE_REMOVE:
            begin
                found = -1;
                for (int i = 0; i < shadow_count && found < 0; i++)
                    if (shadow_rules[i].id == hid)
                        found = i;
                if (found >= 0)
                begin
                    for (int j = found; j + 1 < shadow_count; j++)
                    begin
                        shadow_rules[j] = shadow_rules[j + 1];
                        shadow_hits[j] = shadow_hits[j + 1];
                    end
                    shadow_count--;
                end
                words = {words, make_word(pcmt_pkg::ACT_ACK,
                                          (found >= 0) ? pcmt_pkg::ST_OK : pcmt_pkg::ST_NOTFOUND,
                                          1'b0, nr, hid, '0)};
            end
            pcmt_pkg::MODE_CLEAR:
            begin
                words = {words, make_word(pcmt_pkg::ACT_ACK, pcmt_pkg::ST_OK, 1'b0, nr, '0,
                                          32'(shadow_count))};
                shadow_count = 0;
            end
            pcmt_pkg::MODE_LIST:
            begin
                for (int i = 0; i < shadow_count && i < pcmt_pkg::MAX_RESULTS; i++)
                    words = {words, make_word(pcmt_pkg::ACT_ACK, pcmt_pkg::ST_OK, 1'b1,
                                              shadow_rules[i], shadow_rules[i].id,
                                              shadow_hits[i])};
                if (words.size() == 0)
                    words = {words, make_word(pcmt_pkg::ACT_NONE, pcmt_pkg::ST_EMPTY, 1'b0,
                                              nr, '0, '0)};
            end
            default:
                words = {words, make_word(pcmt_pkg::ACT_NONE, pcmt_pkg::ST_OK, 1'b0,
                                          nr, '0, '0)};
        endcase
        words[words.size() - 1].last = 1'b1;
        pending_words = {pending_words, words};
    endtask

    // Sends one command word; start stays high afterwards until a gap lowers it.
    task automatic send_command(input logic [2:0] m, input logic [31:0] p,
                                input logic [31:0] t, input logic [31:0] v,
                                input logic o, input logic [31:0] hid);
        @(negedge clk);
        mode = m;
        pc = p;
        target = t;
        value = v;
        once = o;
        hook_id = hid;
        start = 1'b1;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        predict_command(m, p, t, v, o, hid);
    endtask

    task automatic idle_gap(input int cycles);
        @(negedge clk);
        start = 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    // Waits until every expected word has arrived and the block has gone quiet.
    task automatic drain_block();
        idle_gap(0);
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic write_ram_bytes(input logic [24:0] bytes);
        drain_block();
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data = bytes;
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        shadow_ram_bytes = bytes;
        @(negedge clk);
        cfg_valid = 1'b0;
        cfg_data = 25'($urandom);
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // Compares each strobed result word with the oldest expectation.
    always @(posedge clk)
    begin
        trig_word_t w;
        if (rst_n && done)
        begin
            if (pending_words.size() == 0)
            begin
                $error("result word with nothing expected");
                fail_count++;
            end
            else
            begin
                w = pending_words.pop_front();
                check_field("action", w.action, action);
                check_field("status", w.status, status);
                check_field("write_target", w.write_target, write_target);
                check_field("write_value", w.write_value, write_value);
                check_field("rule_id", w.rule_id, rule_id);
                check_field("count", w.count, count);
                check_field("entry_pc", w.entry_pc, entry_pc);
                check_field("entry_kind", w.entry_kind, entry_kind);
                check_field("entry_once", w.entry_once, entry_once);
                check_field("entry_enabled", w.entry_enabled, entry_enabled);
                check_field("last", w.last, last);
            end
        end
    end

    // Commands on an empty table, unused modes and add range checks.
    task automatic test_empty_and_ranges();
        send_command(pcmt_pkg::MODE_LIST, '0, '0, '0, 1'b0, '0);
        send_command(pcmt_pkg::MODE_STEP, 32'hFFFF_FFFF, '0, '0, 1'b0, '0);
        send_command(pcmt_pkg::MODE_REMOVE, '0, '0, '0, 1'b0, 32'hFFFF_FFFF);
        send_command(pcmt_pkg::MODE_CLEAR, '0, '0, '0, 1'b0, '0);
        send_command(3'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
        send_command(3'd7, '0, '0, '0, 1'b0, '0);
        send_command(pcmt_pkg::MODE_ADDCOP, 32'h100, 32'd32, 32'h1, 1'b0, '0);
        send_command(pcmt_pkg::MODE_ADDCOP, 32'h100, 32'hFFFF_FFFF, 32'h1, 1'b0, '0);
        send_command(pcmt_pkg::MODE_ADDRAM, 32'h100, shadow_ram_bytes - 3, 32'h2, 1'b0, '0);
        send_command(pcmt_pkg::MODE_ADDRAM, 32'h100, 32'hFFFF_FFFE, 32'h2, 1'b0, '0);
    endtask

    // Firing, once rules, a stale RAM rule and removal with compaction.
    task automatic test_firing();
        send_command(pcmt_pkg::MODE_ADDCOP, 32'h100, 32'd31, 32'hFFFF_FFFF, 1'b1, '0);
        send_command(pcmt_pkg::MODE_ADDRAM, 32'h100, shadow_ram_bytes - 4, 32'hA5A5_5A5A,
                     1'b0, '0);
        send_command(pcmt_pkg::MODE_ADDCOP, 32'h100, 32'd0, 32'h0, 1'b0, '0);
        send_command(pcmt_pkg::MODE_STEP, 32'h100, '0, '0, 1'b0, '0);
        send_command(pcmt_pkg::MODE_STEP, 32'h100, '0, '0, 1'b0, '0);
        send_command(pcmt_pkg::MODE_LIST, '0, '0, '0, 1'b0, '0);
        write_ram_bytes(25'd4);
        send_command(pcmt_pkg::MODE_STEP, 32'h100, '0, '0, 1'b0, '0);
        send_command(pcmt_pkg::MODE_ADDRAM, 32'hFFFF_FFFF, 32'd0, 32'h5, 1'b1, '0);
        send_command(pcmt_pkg::MODE_REMOVE, '0, '0, '0, 1'b0, shadow_next_id - 3);
        send_command(pcmt_pkg::MODE_LIST, '0, '0, '0, 1'b0, '0);
    endtask

    // Filling the table past its capacity, a full step and list, then a clear.
    task automatic test_full_table();
        write_ram_bytes(25'd16777216);
        for (int i = 0; i < TABLE_DEPTH + 1; i++)
            send_command(pcmt_pkg::MODE_ADDCOP, 32'h40, i, $urandom, i[0], '0);
        send_command(pcmt_pkg::MODE_STEP, 32'h40, '0, '0, 1'b0, '0);
        send_command(pcmt_pkg::MODE_LIST, '0, '0, '0, 1'b0, '0);
        send_command(pcmt_pkg::MODE_CLEAR, '0, '0, '0, 1'b0, '0);
    endtask

    // Mostly well-formed traffic over a small pool of pcs, with bursts and gaps.
    task automatic test_random_traffic(input int items);
        logic [31:0] pc_pool [4];
        int          burst_left;
        int          pick;
        logic [31:0] p;
        logic [31:0] t;
        logic [2:0]  m;
        logic [31:0] hid;
        burst_left = 0;
        for (int n = 0; n < items; n++)
        begin
            if (n % 60 == 0)
            begin
                write_ram_bytes(25'($urandom_range(16777216, 4)));
                foreach (pc_pool[k])
                    pc_pool[k] = $urandom;
            end
            if (burst_left == 0)
            begin
                if ($urandom_range(3, 0) != 0)
                    idle_gap($urandom_range(8, 1));
                burst_left = $urandom_range(12, 1);
            end
            burst_left--;
            p = ($urandom_range(9, 0) == 0) ? $urandom : pc_pool[$urandom_range(3, 0)];
            pick = $urandom_range(99, 0);
            if (pick < 40)
                m = pcmt_pkg::MODE_STEP;
            else if (pick < 60)
                m = pcmt_pkg::MODE_ADDCOP;
            else if (pick < 78)
                m = pcmt_pkg::MODE_ADDRAM;
            else if (pick < 88)
                m = pcmt_pkg::MODE_REMOVE;
            else if (pick < 93)
                m = pcmt_pkg::MODE_LIST;
            else if (pick < 96)
                m = pcmt_pkg::MODE_CLEAR;
            else
                m = 3'($urandom_range(7, 6));
            if (m == pcmt_pkg::MODE_ADDCOP)
                t = ($urandom_range(7, 0) == 0) ? $urandom : $urandom_range(31, 0);
            else if (m == pcmt_pkg::MODE_ADDRAM)
                t = ($urandom_range(7, 0) == 0) ? $urandom
                    : $urandom_range(shadow_ram_bytes - 4, 0);
            else
                t = $urandom;
            hid = ($urandom_range(4, 0) == 0) ? $urandom
                  : shadow_next_id - $urandom_range(6, 1);
            send_command(m, p, t, $urandom, 1'($urandom), hid);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        mode = '0;
        pc = '0;
        target = '0;
        value = '0;
        once = 1'b0;
        hook_id = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        fail_count = 0;
        shadow_count = 0;
        shadow_next_id = 32'd1;
        shadow_ram_bytes = pcmt_pkg::RAM_BYTES_RESET;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_and_ranges();
        test_firing();
        test_full_table();
        test_random_traffic(130);
        drain_block();

        if (fail_count == 0)
            $display("tb_pc_match_action_trigger_table_unit OK");
        else
            $display("tb_pc_match_action_trigger_table_unit NOT OK");
        $finish;
    end

    // Watchdog in case the block stops answering.
    initial
    begin
        #5_000_000;
        $display("tb_pc_match_action_trigger_table_unit NOT OK");
        $finish;
    end

endmodule

FILE: pc_match_action_trigger_table_unit.f
src/pcmt_pkg.sv
src/pcmt_store.sv
src/pc_match_action_trigger_table_unit.sv
test/tb_pc_match_action_trigger_table_unit.sv
